[rtl/core/sfcc_pkg.sv]
// Package with the shared types, codes and CRC step of the frame CRC checker.
package sfcc_pkg;

  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_XOR_OUT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY_REFL = 16'h8408;
  localparam logic [9:0]  EXP_LEN_RESET = 10'd8;
  localparam logic [9:0]  COUNT_MAX     = 10'd1023;

  // Depth of the queue between front and back, and its pointer and count widths.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_SHORT   = 2'd1,
    ST_LONG    = 2'd2,
    ST_CRC_ERR = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_END      = 2'd1,
    KIND_BYTE_END = 2'd2
  } kind_e;

  // One classified request as it travels from front to back.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] rx_byte;
  } item_t;

  // Bytewise reflected CRC-16 update, one bit per step.
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[rtl/core/serial_frame_crc_checker_unit.sv]
// Top level of the received-frame CRC-16/X.25 checker.
//
// This block checks one received frame at a time, one request per byte or
// window event. Each request carries an optional byte (byte_valid_i) and an
// optional end of the reception window (window_end_i). Bytes feed a running
// CRC-16/X.25 except the last two, which are held as the received CRC
// (older byte is the low byte). A request that closes the window produces
// exactly one result: the frame status (good, short, too long or CRC
// mismatch), the saturated byte count and the computed CRC; the frame state
// then clears for the next frame. Requests with neither a byte nor a window
// end produce nothing. The block sustains one request per clock cycle as
// long as no result waits: the front end accepts a request every cycle while
// the two-entry queue has room, and the back end retires one queued request
// per cycle, doing the whole bytewise CRC update in that cycle. An accepted
// request is written into the queue; a window-closing request at the head
// of the queue loads the result register when it is retired, and the result
// is offered from that register. While a result waits, a window-closing
// request at the head of the queue waits for it and the requests behind it
// wait in turn; once the queue holds two requests the input is stalled. The
// expected length register resets to eight and is written through the
// configuration channel, which is always ready; it must be written only
// while no frame is in flight.
module serial_frame_crc_checker_unit #(
  parameter int MAX_FRAME_BYTES = 1023
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [9:0]  cfg_expected_length_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        byte_valid_i,
  input  logic        window_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  frame_status_o,
  output logic [9:0]  byte_count_o,
  output logic [15:0] computed_crc_o
);

  logic [9:0]      expected_length_q, expected_length_d;
  logic            q_full, q_empty, q_push, q_pop;
  sfcc_pkg::item_t q_in_item, q_head;

  // The single configuration register; every write request is taken at once.
  assign cfg_ready_o       = 1'b1;
  assign expected_length_d = cfg_valid_i ? cfg_expected_length_i : expected_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_length_q <= sfcc_pkg::EXP_LEN_RESET;
    end else begin
      expected_length_q <= expected_length_d;
    end
  end

  // Front end: accept and classify requests.
  sfcc_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .byte_valid_i (byte_valid_i),
    .window_end_i (window_end_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_item_o     (q_in_item)
  );

  // Queue that lets the front and back ends stall independently.
  sfcc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (q_in_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  // Back end: frame state update and the registered result.
  sfcc_back #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .expected_length_i (expected_length_q),
    .q_empty_i         (q_empty),
    .q_head_i          (q_head),
    .q_pop_o           (q_pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .frame_status_o    (frame_status_o),
    .byte_count_o      (byte_count_o),
    .computed_crc_o    (computed_crc_o)
  );

endmodule

[rtl/core/sfcc_front.sv]
// Front end: takes input requests and classifies them for the queue.
module sfcc_front (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               byte_valid_i,
  input  logic               window_end_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output sfcc_pkg::item_t    q_item_o
);

  logic accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Requests with neither a byte nor a window end change nothing and are dropped.
  assign q_push_o = accept && (byte_valid_i || window_end_i);

  always_comb begin
    q_item_o.rx_byte = rx_byte_i;
    if (byte_valid_i && window_end_i) begin
      q_item_o.kind = sfcc_pkg::KIND_BYTE_END;
    end else if (window_end_i) begin
      q_item_o.kind = sfcc_pkg::KIND_END;
    end else begin
      q_item_o.kind = sfcc_pkg::KIND_BYTE;
    end
  end

endmodule

[rtl/core/sfcc_queue.sv]
// Small register queue that decouples the front end from the back end.
module sfcc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sfcc_pkg::item_t push_item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output sfcc_pkg::item_t head_o
);

  sfcc_pkg::item_t                      mem_q [sfcc_pkg::QUEUE_DEPTH];
  logic [sfcc_pkg::QUEUE_PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [sfcc_pkg::QUEUE_PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [sfcc_pkg::QUEUE_CNT_W-1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == sfcc_pkg::QUEUE_CNT_W'(sfcc_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[rtl/core/sfcc_back.sv]
// Back end: running CRC, byte count, tail delay and the registered result.
module sfcc_back #(
  parameter int MAX_FRAME_BYTES = 1023
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [9:0]      expected_length_i,
  input  logic            q_empty_i,
  input  sfcc_pkg::item_t q_head_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      frame_status_o,
  output logic [9:0]      byte_count_o,
  output logic [15:0]     computed_crc_o
);

  localparam int CountCap = (MAX_FRAME_BYTES > 1023) ? 1023 : MAX_FRAME_BYTES;

  logic [15:0] crc_q, crc_d;
  logic [9:0]  seen_q, seen_d;
  logic [7:0]  tail0_q, tail0_d;
  logic [7:0]  tail1_q, tail1_d;
  logic        out_valid_q, out_valid_d;
  logic [1:0]  status_q;
  logic [9:0]  count_q;
  logic [15:0] crc_out_q;

  logic        has_byte, has_end, out_free, load_out;
  logic [15:0] crc_n, crc_fin;
  logic [9:0]  seen_n;
  logic [7:0]  tail0_n, tail1_n;
  sfcc_pkg::status_e status_n;

  assign has_byte = (q_head_i.kind == sfcc_pkg::KIND_BYTE) ||
                    (q_head_i.kind == sfcc_pkg::KIND_BYTE_END);
  assign has_end  = (q_head_i.kind == sfcc_pkg::KIND_END) ||
                    (q_head_i.kind == sfcc_pkg::KIND_BYTE_END);
  assign out_free = !out_valid_q || out_ready_i;
  // Only a request that closes the window needs room in the output register.
  assign q_pop_o  = !q_empty_i && (!has_end || out_free);
  assign load_out = q_pop_o && has_end;

  // Frame state after this request's byte.
  always_comb begin
    crc_n   = crc_q;
    seen_n  = seen_q;
    tail0_n = tail0_q;
    tail1_n = tail1_q;
    if (has_byte && (seen_q < 10'(CountCap))) begin
      if (seen_q >= 10'd2) begin
        crc_n = sfcc_pkg::crc_feed(crc_q, tail0_q);
      end
      tail0_n = tail1_q;
      tail1_n = q_head_i.rx_byte;
      seen_n  = seen_q + 10'd1;
    end
  end

  assign crc_fin = crc_n ^ sfcc_pkg::CRC_XOR_OUT;

  always_comb begin
    if (seen_n < expected_length_i) begin
      status_n = sfcc_pkg::ST_SHORT;
    end else if (seen_n != expected_length_i) begin
      status_n = sfcc_pkg::ST_LONG;
    end else if (expected_length_i < 10'd2) begin
      status_n = sfcc_pkg::ST_CRC_ERR;
    end else if ({tail1_n, tail0_n} != crc_fin) begin
      status_n = sfcc_pkg::ST_CRC_ERR;
    end else begin
      status_n = sfcc_pkg::ST_GOOD;
    end
  end

  always_comb begin
    crc_d       = crc_q;
    seen_d      = seen_q;
    tail0_d     = tail0_q;
    tail1_d     = tail1_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (q_pop_o) begin
      if (has_end) begin
        crc_d       = sfcc_pkg::CRC_INIT;
        seen_d      = '0;
        tail0_d     = '0;
        tail1_d     = '0;
        out_valid_d = 1'b1;
      end else begin
        crc_d   = crc_n;
        seen_d  = seen_n;
        tail0_d = tail0_n;
        tail1_d = tail1_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= sfcc_pkg::CRC_INIT;
      seen_q      <= '0;
      tail0_q     <= '0;
      tail1_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      crc_q       <= crc_d;
      seen_q      <= seen_d;
      tail0_q     <= tail0_d;
      tail1_q     <= tail1_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      status_q  <= status_n;
      count_q   <= seen_n;
      crc_out_q <= crc_fin;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_status_o = status_q;
  assign byte_count_o   = count_q;
  assign computed_crc_o = crc_out_q;

endmodule

[rtl/core/sfcc_assert.sv]
// Port-level checker for the frame CRC checker, bound to its top level.
module sfcc_assert (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  frame_status_o,
  input logic [9:0]  byte_count_o,
  input logic [15:0] computed_crc_o
);

  // A stalled result stays offered.
  a_out_hold_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its contents.
  a_out_hold_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(frame_status_o) &&
      $stable(byte_count_o) && $stable(computed_crc_o))
    else $error("result changed while stalled");

  // A good frame has at least its two CRC bytes.
  a_good_needs_crc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_status_o == sfcc_pkg::ST_GOOD) |-> (byte_count_o >= 10'd2))
    else $error("good status on a frame without CRC bytes");

  // With two or fewer bytes nothing reaches the CRC.
  a_empty_crc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (byte_count_o <= 10'd2) |-> (computed_crc_o == 16'h0000))
    else $error("nonzero CRC over an empty body");

endmodule

bind serial_frame_crc_checker_unit sfcc_assert u_sfcc_assert (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .frame_status_o (frame_status_o),
  .byte_count_o   (byte_count_o),
  .computed_crc_o (computed_crc_o)
);

[tb/tb_serial_frame_crc_checker_unit.sv]
// Self-checking testbench of the received-frame CRC-16/X.25 checker.
module tb_serial_frame_crc_checker_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_PERIOD    = 10;
  localparam int          RESET_CYCLES  = 8;
  localparam int          MAX_BYTES     = 1023;
  // The byte counter saturates at the smaller of the parameter and its 10-bit range.
  localparam int unsigned FRAME_CAP     = (MAX_BYTES > 1023) ? 1023 : MAX_BYTES;
  // A window-closing request is offered as a report once it has left the
  // queue and loaded the result register; this leaves ample margin.
  localparam int          SETTLE_CYCLES = 8;
  // The directed part already sends over a thousand requests, most of them in
  // the saturating frame, so the random part adds only a modest share.
  localparam int unsigned RANDOM_ITEMS  = 100;
  // This limit lies far above the slowest legal run, even if every gap and
  // stall were long.
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  // One request on the input channel.
  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       window_end;
  } rx_req_t;

  // One frame report as the block should deliver it.
  typedef struct packed {
    sfcc_pkg::status_e status;
    logic [9:0]        count;
    logic [15:0]       crc;
  } frame_report_t;

  logic        clk_i                 = 1'b0;
  logic        rst_ni                = 1'b0;
  logic        cfg_valid_i           = 1'b0;
  logic        cfg_ready_o;
  logic [9:0]  cfg_expected_length_i = sfcc_pkg::EXP_LEN_RESET;
  logic        in_valid_i            = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i             = 8'h00;
  logic        byte_valid_i          = 1'b0;
  logic        window_end_i          = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i           = 1'b0;
  logic [1:0]  frame_status_o;
  logic [9:0]  byte_count_o;
  logic [15:0] computed_crc_o;

  // Requests waiting to be driven, and reports waiting to be seen.
  rx_req_t       request_backlog[$];
  frame_report_t pending_reports[$];

  // Own copy of the block's frame state and its length register.
  logic [15:0] crc_acc    = sfcc_pkg::CRC_INIT;
  int unsigned seen_bytes = 0;
  logic [7:0]  tail_q[2]  = '{8'h00, 8'h00};
  logic [9:0]  exp_len    = sfcc_pkg::EXP_LEN_RESET;

  int unsigned mismatch_count = 0;
  int unsigned queued_items   = 0;
  int unsigned cycle_count    = 0;

  serial_frame_crc_checker_unit #(
    .MAX_FRAME_BYTES(MAX_BYTES)
  ) i_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_expected_length_i(cfg_expected_length_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .rx_byte_i            (rx_byte_i),
    .byte_valid_i         (byte_valid_i),
    .window_end_i         (window_end_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .frame_status_o       (frame_status_o),
    .byte_count_o         (byte_count_o),
    .computed_crc_o       (computed_crc_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Reflected CRC-16 step written as a serial LFSR: the feedback bit is the
  // low CRC bit XOR the next data bit, taken LSB first.
  function automatic logic [15:0] x25_update(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ data[i];
      r  = r >> 1;
      if (fb) begin
        r = r ^ sfcc_pkg::CRC_POLY_REFL;
      end
    end
    return r;
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  // A calm side never idles.
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Predicts the effect of one accepted request. A byte shifts the two-byte
  // delay line, and the byte falling out of it enters the CRC. Once the count
  // has saturated, further bytes are dropped completely. A window end yields
  // a report and clears the frame state; the length register stays.
  task automatic absorb_request(input rx_req_t req);
    frame_report_t rep;
    logic [15:0]   fcs_out;
    logic [15:0]   fcs_rx;
    if (req.byte_valid && seen_bytes < FRAME_CAP) begin
      if (seen_bytes >= 2) begin
        crc_acc = x25_update(crc_acc, tail_q[0]);
      end
      tail_q[0] = tail_q[1];
      tail_q[1] = req.data;
      seen_bytes++;
    end
    if (req.window_end) begin
      fcs_out = crc_acc ^ sfcc_pkg::CRC_XOR_OUT;
      // The older held byte is the low byte of the received CRC.
      fcs_rx  = {tail_q[1], tail_q[0]};
      if (seen_bytes < exp_len) begin
        rep.status = sfcc_pkg::ST_SHORT;
      end else if (seen_bytes != exp_len) begin
        rep.status = sfcc_pkg::ST_LONG;
      end else if (exp_len < 2) begin
        // A frame shorter than two bytes has no room for a CRC.
        rep.status = sfcc_pkg::ST_CRC_ERR;
      end else if (fcs_rx != fcs_out) begin
        rep.status = sfcc_pkg::ST_CRC_ERR;
      end else begin
        rep.status = sfcc_pkg::ST_GOOD;
      end
      rep.count = seen_bytes[9:0];
      rep.crc   = fcs_out;
      pending_reports.push_back(rep);
      crc_acc    = sfcc_pkg::CRC_INIT;
      seen_bytes = 0;
      tail_q[0]  = 8'h00;
      tail_q[1]  = 8'h00;
    end
  endtask

  // Driver: presents the backlog one request at a time. The predictor runs on
  // the edge where a request is accepted, and the next request, if any and
  // if no gap is due, goes out on that same edge so valid stays high.
  always @(posedge clk_i) begin : driver_proc
    static rx_req_t     cur_req   = '0;
    static int unsigned send_gap  = 0;
    static bit          send_calm = 1'b0;
    logic               busy;
    if (rst_ni) begin
      busy = in_valid_i;
      if ($urandom_range(0, 149) == 0) begin
        send_calm = !send_calm;
      end
      if (in_valid_i && in_ready_o) begin
        absorb_request(cur_req);
        busy     = 1'b0;
        send_gap = pick_gap(send_calm);
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (request_backlog.size() > 0) begin
          cur_req      = request_backlog.pop_front();
          rx_byte_i    <= cur_req.data;
          byte_valid_i <= cur_req.byte_valid;
          window_end_i <= cur_req.window_end;
          busy         = 1'b1;
        end
      end
      in_valid_i <= busy;
    end
  end

  // Monitor: compares every accepted report with the oldest prediction and
  // throttles the output side with random stalls.
  always @(posedge clk_i) begin : monitor_proc
    static int unsigned take_stall = 0;
    static bit          take_calm  = 1'b0;
    frame_report_t      want;
    if (rst_ni) begin
      if ($urandom_range(0, 149) == 0) begin
        take_calm = !take_calm;
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_reports.size() == 0) begin
          report_mismatch($sformatf("unexpected report: status %0d count %0d crc %h",
                                    frame_status_o, byte_count_o, computed_crc_o));
        end else begin
          want = pending_reports.pop_front();
          if (frame_status_o !== want.status) begin
            report_mismatch($sformatf("frame_status %0d, predicted %0d",
                                      frame_status_o, want.status));
          end
          if (byte_count_o !== want.count) begin
            report_mismatch($sformatf("byte_count %0d, predicted %0d",
                                      byte_count_o, want.count));
          end
          if (computed_crc_o !== want.crc) begin
            report_mismatch($sformatf("computed_crc %h, predicted %h",
                                      computed_crc_o, want.crc));
          end
        end
      end
      if (take_stall > 0) begin
        take_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        take_stall  = pick_gap(take_calm);
      end
    end
  end

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin : watchdog_proc
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Appends one request to the backlog. Requests with neither a byte nor a
  // window end do nothing in the block and are not counted.
  task automatic queue_req(input logic [7:0] data, input logic bval, input logic wend);
    rx_req_t req;
    req.data       = data;
    req.byte_valid = bval;
    req.window_end = wend;
    request_backlog.push_back(req);
    if (bval || wend) begin
      queued_items++;
    end
  endtask

  // Builds a frame of n_bytes with random content. The last two bytes carry
  // the CRC of the rest, little-endian, or a corrupted one. overrun adds
  // random bytes after the CRC. The window closes on the last byte or, with
  // end_apart or no bytes at all, on a request of its own. Idle requests are
  // sprinkled into short frames.
  task automatic queue_frame(input int unsigned n_bytes, input bit good_crc,
                             input int unsigned overrun, input bit end_apart);
    logic [7:0]  body[$];
    logic [15:0] fcs;
    int unsigned total;
    fcs = sfcc_pkg::CRC_INIT;
    for (int unsigned i = 0; i < n_bytes; i++) begin
      body.push_back(8'($urandom));
    end
    if (n_bytes >= 2) begin
      for (int unsigned i = 0; i < n_bytes - 2; i++) begin
        fcs = x25_update(fcs, body[i]);
      end
      fcs = fcs ^ sfcc_pkg::CRC_XOR_OUT;
      if (!good_crc) begin
        fcs = fcs ^ 16'($urandom_range(1, 65535));
      end
      body[n_bytes - 2] = fcs[7:0];
      body[n_bytes - 1] = fcs[15:8];
    end
    for (int unsigned i = 0; i < overrun; i++) begin
      body.push_back(8'($urandom));
    end
    total = body.size();
    for (int unsigned i = 0; i < total; i++) begin
      if (total < 64 && $urandom_range(0, 7) == 0) begin
        queue_req(8'($urandom), 1'b0, 1'b0);
      end
      queue_req(body[i], 1'b1, (i == total - 1) && !end_apart);
    end
    if (end_apart || total == 0) begin
      queue_req(8'($urandom), 1'b0, 1'b1);
    end
  endtask

  // Mostly well-formed frames; the rest carry a bad CRC, stop short or run long.
  task automatic queue_random_frame();
    int unsigned pick;
    bit          apart;
    pick  = $urandom_range(0, 99);
    apart = ($urandom_range(0, 3) == 0);
    if (pick < 70) begin
      queue_frame(exp_len, 1'b1, 0, apart);
    end else if (pick < 80) begin
      queue_frame(exp_len, 1'b0, 0, apart);
    end else if (pick < 90 && exp_len > 0) begin
      queue_frame($urandom_range(0, exp_len - 1), 1'b1, 0, apart);
    end else begin
      queue_frame(exp_len, 1'b1, $urandom_range(1, 3), apart);
    end
  endtask

  // Waits until every request has gone out and every report has come back,
  // then lets the pipeline run empty. Polled on the falling edge so that it
  // never races the clocked driver and monitor.
  task automatic settle();
    do begin
      @(negedge clk_i);
    end while (request_backlog.size() != 0 || in_valid_i || pending_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Writes the expected length; only called while the block is idle.
  task automatic write_expected_length(input logic [9:0] value);
    @(posedge clk_i);
    cfg_expected_length_i <= value;
    cfg_valid_i           <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    exp_len = value;
    @(negedge clk_i);
  endtask

  initial begin : stimulus_proc
    int unsigned random_start;
    int unsigned roll;
    int unsigned n_frames;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part. A good frame at the reset length of eight.
    queue_frame(8, 1'b1, 0, 1'b0);

    // Length two: the CRC covers nothing and reads zero, so two zero bytes
    // make a good frame; a corrupted pair and an empty window follow.
    settle();
    write_expected_length(10'd2);
    queue_frame(2, 1'b1, 0, 1'b0);
    queue_frame(2, 1'b0, 0, 1'b1);
    queue_req(8'h00, 1'b0, 1'b1);

    // Length one: a frame of exactly one byte has no room for a CRC.
    settle();
    write_expected_length(10'd1);
    queue_frame(1, 1'b1, 0, 1'b0);
    queue_req(8'($urandom), 1'b0, 1'b1);

    // Length zero: an empty window matches it but still fails the CRC check,
    // and a single all-ones byte makes it too long.
    settle();
    write_expected_length(10'd0);
    queue_req(8'($urandom), 1'b0, 1'b1);
    queue_req(8'hFF, 1'b1, 1'b0);
    queue_req(8'h5A, 1'b0, 1'b1);

    // Smallest length with a byte ahead of the CRC, then a one-byte short frame.
    settle();
    write_expected_length(10'd3);
    queue_frame(3, 1'b1, 0, 1'b1);
    queue_frame(1, 1'b1, 0, 1'b0);

    // Largest length. The bytes after the 1023rd are dropped, so the count
    // saturates and the frame still checks good.
    settle();
    write_expected_length(10'd1023);
    queue_frame(1023, 1'b1, 6, 1'b0);
    queue_frame(5, 1'b1, 0, 1'b1);

    // Random part: phases of frames, each at a length of its own. Every
    // phase change makes the sender wait until all reports are in.
    random_start = queued_items;
    while (queued_items - random_start < RANDOM_ITEMS) begin
      settle();
      roll = $urandom_range(0, 99);
      if (roll < 85) begin
        write_expected_length(10'($urandom_range(3, 12)));
      end else if (roll < 95) begin
        write_expected_length(10'($urandom_range(13, 64)));
      end else begin
        write_expected_length(10'($urandom_range(0, 2)));
      end
      n_frames = $urandom_range(3, 8);
      for (int unsigned f = 0;
           f < n_frames && queued_items - random_start < RANDOM_ITEMS; f++) begin
        queue_random_frame();
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[serial_frame_crc_checker_unit.f]
rtl/core/sfcc_pkg.sv
rtl/core/sfcc_front.sv
rtl/core/sfcc_queue.sv
rtl/core/sfcc_back.sv
rtl/core/serial_frame_crc_checker_unit.sv
rtl/core/sfcc_assert.sv
tb/tb_serial_frame_crc_checker_unit.sv
